/* design/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, constants and table functions of the LED pattern controller.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLOW_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_FAST_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_STABLE_COUNT = 2'd2;

  // Input opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Result kinds.
  localparam logic KIND_LED   = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Only the first five receive buffer entries are ever inspected.
  localparam int CMD_LEN = 5;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Characters used by the command parser.
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_4     = 8'h34;

  // Reply texts, first character in the most significant byte.
  localparam int MSG_ON_LEN    = 11;
  localparam int MSG_OFF_LEN   = 12;
  localparam int MSG_PROG_LEN  = 10;
  localparam int MSG_SPEED_LEN = 9;
  localparam int MSG_ERR_LEN   = 9;
  localparam int MSG_PROG_DIGIT  = 7;
  localparam int MSG_SPEED_DIGIT = 6;

  localparam logic [8*MSG_ON_LEN-1:0]    MSG_ON_TXT    = {"UKLJUCENO", 8'h0D, 8'h0A};
  localparam logic [8*MSG_OFF_LEN-1:0]   MSG_OFF_TXT   = {"ISKLJUCENO", 8'h0D, 8'h0A};
  localparam logic [8*MSG_PROG_LEN-1:0]  MSG_PROG_TXT  = {"PROGRAM1", 8'h0D, 8'h0A};
  localparam logic [8*MSG_SPEED_LEN-1:0] MSG_SPEED_TXT = {"BRZINA1", 8'h0D, 8'h0A};
  localparam logic [8*MSG_ERR_LEN-1:0]   MSG_ERR_TXT   = {"GRESKA!", 8'h0D, 8'h0A};

  typedef enum logic [2:0] {
    MSG_ON    = 3'd0,
    MSG_OFF   = 3'd1,
    MSG_PROG  = 3'd2,
    MSG_SPEED = 3'd3,
    MSG_ERR   = 3'd4
  } msg_t;

  // One queued job: either a tick result or a reply to expand.
  typedef struct packed {
    logic       is_reply;
    msg_t       msg;
    logic [7:0] digit;
    logic [7:0] led;
  } job_t;

  // Index of the final character of a reply.
  function automatic logic [3:0] msg_last(msg_t id);
    logic [3:0] n;
    unique case (id)
      MSG_ON:    n = 4'(MSG_ON_LEN - 1);
      MSG_OFF:   n = 4'(MSG_OFF_LEN - 1);
      MSG_PROG:  n = 4'(MSG_PROG_LEN - 1);
      MSG_SPEED: n = 4'(MSG_SPEED_LEN - 1);
      default:   n = 4'(MSG_ERR_LEN - 1);
    endcase
    return n;
  endfunction

  // Character k of a reply, with the digit placed where the text has one.
  function automatic logic [7:0] msg_char(msg_t id, logic [3:0] k, logic [7:0] digit);
    logic [7:0] c;
    int         pos;
    pos = int'(k);
    c   = 8'h00;
    unique case (id)
      MSG_ON: begin
        if (pos < MSG_ON_LEN) c = MSG_ON_TXT[8*(MSG_ON_LEN-1-pos) +: 8];
      end
      MSG_OFF: begin
        if (pos < MSG_OFF_LEN) c = MSG_OFF_TXT[8*(MSG_OFF_LEN-1-pos) +: 8];
      end
      MSG_PROG: begin
        if (pos == MSG_PROG_DIGIT) c = digit;
        else if (pos < MSG_PROG_LEN) c = MSG_PROG_TXT[8*(MSG_PROG_LEN-1-pos) +: 8];
      end
      MSG_SPEED: begin
        if (pos == MSG_SPEED_DIGIT) c = digit;
        else if (pos < MSG_SPEED_LEN) c = MSG_SPEED_TXT[8*(MSG_SPEED_LEN-1-pos) +: 8];
      end
      default: begin
        if (pos < MSG_ERR_LEN) c = MSG_ERR_TXT[8*(MSG_ERR_LEN-1-pos) +: 8];
      end
    endcase
    return c;
  endfunction

  // Pattern tables; p is the program number minus one.
  function automatic logic [7:0] pattern_at(logic [1:0] p, logic [2:0] i);
    logic [7:0] v;
    unique case (p)
      2'd0: v = i[0] ? 8'hFF : 8'h00;
      2'd1: v = 8'(8'h01 << i);
      2'd2: begin
        unique case (i)
          3'd0:    v = 8'h81;
          3'd1:    v = 8'h42;
          3'd2:    v = 8'h24;
          3'd3:    v = 8'h18;
          3'd4:    v = 8'h24;
          3'd5:    v = 8'h42;
          default: v = 8'h81;
        endcase
      end
      default: v = 8'(8'h88 >> i[1:0]);
    endcase
    return v;
  endfunction

  // Index of the final entry of each pattern.
  function automatic logic [2:0] pattern_last(logic [1:0] p);
    logic [2:0] n;
    unique case (p)
      2'd0:    n = 3'd1;
      2'd1:    n = 3'd7;
      2'd2:    n = 3'd5;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

endpackage

/* design/led_pattern_controller.sv */
// An accepted input beat's job is written to the job queue, then loaded into the output register.
// Throughput: one input beat per cycle while in_stall is low; a tick yields one result beat,
// and a reply of n characters (9 to 12) keeps the output stage busy for n result beats.
// The two-entry job queue decides when the input stalls behind a reply burst.
// Synchronous reset (rst_n low) clears control state, not queue entries or output payload,
// and restores 200, 100, 5 in the period and stable-count registers; there is no clearing pass.
// ----------------------------------------------------------------------------
// led_pattern_controller
// Button and serial command driven LED pattern generator with text replies.
// ----------------------------------------------------------------------------
module led_pattern_controller #(
  parameter int RX_DEPTH = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic       in_run_pin,
  input  logic       in_program_pin,
  input  logic       in_speed_pin,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_led,
  output logic [7:0] out_reply_char,
  output logic       out_last
);

  logic          push_valid, q_full, head_valid, pop;
  lpc_pkg::job_t push_job, head_job;

  assign in_stall = q_full;

  // Front: accept beats and update control state.
  lpc_front #(
    .RX_DEPTH(RX_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_opcode     (in_opcode),
    .in_run_pin    (in_run_pin),
    .in_program_pin(in_program_pin),
    .in_speed_pin  (in_speed_pin),
    .in_rx_byte    (in_rx_byte),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_job      (push_job)
  );

  // Job queue.
  lpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  // Back: emit result beats.
  lpc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_led       (out_led),
    .out_reply_char(out_reply_char),
    .out_last      (out_last)
  );

endmodule

/* design/lpc_front.sv */
// ----------------------------------------------------------------------------
// lpc_front
// Accepts tick and serial beats, updates timer, debounce, run and pattern
// state, parses commands, and pushes one job per beat that has a result.
// ----------------------------------------------------------------------------
module lpc_front #(
  parameter int RX_DEPTH = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_write_en,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          in_valid,
  input  logic          in_opcode,
  input  logic          in_run_pin,
  input  logic          in_program_pin,
  input  logic          in_speed_pin,
  input  logic [7:0]    in_rx_byte,
  input  logic          q_full,
  output logic          push_valid,
  output lpc_pkg::job_t push_job
);

  localparam int POS_W = $clog2(RX_DEPTH);
  localparam int PIN_RUN = 0;
  localparam int PIN_PROG = 1;
  localparam int PIN_SPEED = 2;
  localparam int CMD_LEN_W = lpc_pkg::CMD_LEN;

  // Configuration registers.
  logic [7:0] slow_r, fast_r;
  logic [2:0] stable_r;

  // Timer, debounce and control state.
  logic [7:0] tick_r, tick_nxt;
  logic       step_r, step_nxt;
  logic [2:0] prev_raw_r, prev_raw_nxt;
  logic [2:0] rc_r [3];
  logic [2:0] rc_nxt [3];
  logic [2:0] rc_inc [3];
  logic [2:0] clean_r, clean_nxt;
  logic [2:0] fall;
  logic       running_r, running_nxt;
  logic [1:0] prog_r, prog_nxt;
  logic       speed_r, speed_nxt;
  logic [2:0] idx_r [4];
  logic [2:0] idx_nxt [4];
  logic [7:0] led_r, led_nxt;

  // Receive buffer (entries that the parser reads) and write position.
  logic [7:0]       buf_r [CMD_LEN_W];
  logic [7:0]       buf_nxt [CMD_LEN_W];
  logic [7:0]       view [CMD_LEN_W];
  logic [POS_W-1:0] pos_r, pos_nxt, pos0;

  logic [7:0] period;
  logic [7:0] tick_inc;
  logic [2:0] raw;
  logic       accept;
  lpc_pkg::msg_t msg;

  assign accept = in_valid && !q_full;
  assign raw    = {in_speed_pin, in_program_pin, in_run_pin};

  // Next state of everything the front keeps.
  always_comb begin
    tick_nxt     = tick_r;
    step_nxt     = step_r;
    prev_raw_nxt = prev_raw_r;
    clean_nxt    = clean_r;
    running_nxt  = running_r;
    prog_nxt     = prog_r;
    speed_nxt    = speed_r;
    led_nxt      = led_r;
    pos_nxt      = pos_r;
    msg          = lpc_pkg::MSG_ERR;
    push_valid   = 1'b0;
    period       = speed_r ? fast_r : slow_r;
    tick_inc     = tick_r + 8'd1;
    pos0         = (in_rx_byte == lpc_pkg::CH_OPEN) ? '0 : pos_r;
    fall         = '0;
    for (int i = 0; i < 3; i++) begin
      rc_nxt[i] = rc_r[i];
      rc_inc[i] = rc_r[i] + 3'd1;
    end
    for (int i = 0; i < 4; i++) begin
      idx_nxt[i] = idx_r[i];
    end
    for (int k = 0; k < CMD_LEN_W; k++) begin
      buf_nxt[k] = buf_r[k];
      view[k]    = (pos0 == POS_W'(k)) ? in_rx_byte : buf_r[k];
    end

    if (accept && in_opcode == lpc_pkg::OP_TICK) begin
      // Tick counter and step flag.
      if (tick_inc == period) begin
        tick_nxt = 8'd0;
        step_nxt = 1'b1;
      end else begin
        tick_nxt = tick_inc;
      end
      // Debounce each pin by counting equal samples.
      for (int i = 0; i < 3; i++) begin
        if (raw[i] == prev_raw_r[i]) begin
          if (rc_inc[i] >= stable_r) begin
            clean_nxt[i] = raw[i];
            rc_nxt[i]    = 3'd0;
          end else begin
            rc_nxt[i] = rc_inc[i];
          end
        end else begin
          rc_nxt[i] = 3'd0;
        end
      end
      prev_raw_nxt = raw;
      fall         = clean_r & ~clean_nxt;
      // Button actions on falling debounced edges.
      if (fall[PIN_RUN]) begin
        running_nxt = !running_r;
        if (!running_r) tick_nxt = 8'd0;
      end
      if (fall[PIN_SPEED]) speed_nxt = !speed_r;
      if (fall[PIN_PROG]) prog_nxt = prog_r + 2'd1;
      // Pattern step.
      if (running_nxt) begin
        if (step_nxt) begin
          led_nxt = lpc_pkg::pattern_at(prog_nxt, idx_r[prog_nxt]);
          idx_nxt[prog_nxt] = (idx_r[prog_nxt] == lpc_pkg::pattern_last(prog_nxt)) ?
                              3'd0 : idx_r[prog_nxt] + 3'd1;
          step_nxt = 1'b0;
        end
      end else begin
        led_nxt = 8'd0;
      end
      push_valid = 1'b1;
    end else if (accept) begin
      // Store the byte where the parser can see it.
      for (int k = 0; k < CMD_LEN_W; k++) begin
        if (pos0 == POS_W'(k)) buf_nxt[k] = in_rx_byte;
      end
      if (in_rx_byte == lpc_pkg::CH_CLOSE) begin
        push_valid = 1'b1;
        if (view[0] == lpc_pkg::CH_OPEN && view[1] == lpc_pkg::CH_O &&
            view[2] == lpc_pkg::CH_N && view[3] == lpc_pkg::CH_CLOSE) begin
          running_nxt = 1'b1;
          prog_nxt    = 2'd0;
          msg         = lpc_pkg::MSG_ON;
        end else if (view[0] == lpc_pkg::CH_OPEN && view[1] == lpc_pkg::CH_O &&
                     view[2] == lpc_pkg::CH_F && view[3] == lpc_pkg::CH_F &&
                     view[4] == lpc_pkg::CH_CLOSE) begin
          running_nxt = 1'b0;
          msg         = lpc_pkg::MSG_OFF;
        end else if (view[0] == lpc_pkg::CH_OPEN && view[1] == lpc_pkg::CH_P &&
                     view[2] == lpc_pkg::CH_COLON) begin
          if (view[3] >= lpc_pkg::CH_1 && view[3] <= lpc_pkg::CH_4 &&
              view[4] == lpc_pkg::CH_CLOSE) begin
            prog_nxt = view[3][1:0] - 2'd1;
            msg      = lpc_pkg::MSG_PROG;
          end
        end else if (view[0] == lpc_pkg::CH_OPEN && view[1] == lpc_pkg::CH_B &&
                     view[2] == lpc_pkg::CH_COLON) begin
          if ((view[3] == lpc_pkg::CH_1 || view[3] == lpc_pkg::CH_2) &&
              view[4] == lpc_pkg::CH_CLOSE) begin
            speed_nxt = (view[3] == lpc_pkg::CH_2);
            msg       = lpc_pkg::MSG_SPEED;
          end
        end
        buf_nxt[0] = 8'd0;
        pos_nxt    = POS_W'(1);
      end else begin
        pos_nxt = (pos0 == POS_W'(RX_DEPTH - 1)) ? '0 : pos0 + POS_W'(1);
      end
    end
  end

  // Job handed to the back end.
  always_comb begin
    push_job.is_reply = in_opcode;
    push_job.msg      = msg;
    push_job.digit    = view[3];
    push_job.led      = (in_opcode == lpc_pkg::OP_TICK) ? led_nxt : led_r;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r   <= 8'd200;
      fast_r   <= 8'd100;
      stable_r <= 3'd5;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        lpc_pkg::CFG_SLOW_PERIOD:  slow_r   <= cfg_data;
        lpc_pkg::CFG_FAST_PERIOD:  fast_r   <= cfg_data;
        lpc_pkg::CFG_STABLE_COUNT: stable_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= 8'd0;
      step_r     <= 1'b0;
      prev_raw_r <= '1;
      clean_r    <= '1;
      running_r  <= 1'b0;
      prog_r     <= 2'd0;
      speed_r    <= 1'b0;
      led_r      <= 8'd0;
      pos_r      <= '0;
      for (int i = 0; i < 3; i++) rc_r[i] <= 3'd0;
      for (int i = 0; i < 4; i++) idx_r[i] <= 3'd0;
      for (int k = 0; k < CMD_LEN_W; k++) buf_r[k] <= 8'd0;
    end else begin
      tick_r     <= tick_nxt;
      step_r     <= step_nxt;
      prev_raw_r <= prev_raw_nxt;
      clean_r    <= clean_nxt;
      running_r  <= running_nxt;
      prog_r     <= prog_nxt;
      speed_r    <= speed_nxt;
      led_r      <= led_nxt;
      pos_r      <= pos_nxt;
      for (int i = 0; i < 3; i++) rc_r[i] <= rc_nxt[i];
      for (int i = 0; i < 4; i++) idx_r[i] <= idx_nxt[i];
      for (int k = 0; k < CMD_LEN_W; k++) buf_r[k] <= buf_nxt[k];
    end
  end

endmodule

/* design/lpc_queue.sv */
// ----------------------------------------------------------------------------
// lpc_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module lpc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lpc_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output lpc_pkg::job_t head_job
);

  localparam int DEPTH = lpc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpc_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      if (pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

/* design/lpc_back.sv */
// ----------------------------------------------------------------------------
// lpc_back
// Turns queued jobs into result beats: one LED beat per tick job, one beat
// per character of a reply job, held in an output register.
// ----------------------------------------------------------------------------
module lpc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  lpc_pkg::job_t head_job,
  output logic          pop,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          out_kind,
  output logic [7:0]    out_led,
  output logic [7:0]    out_reply_char,
  output logic          out_last
);

  logic       out_valid_r;
  logic       kind_r, last_r;
  logic [7:0] led_r, char_r;
  logic [3:0] chr_r;
  logic       load, final_beat;

  assign load       = head_valid && (!out_valid_r || !out_stall);
  assign final_beat = !head_job.is_reply || (chr_r == lpc_pkg::msg_last(head_job.msg));
  assign pop        = load && final_beat;

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_led        = led_r;
  assign out_reply_char = char_r;
  assign out_last       = last_r;

  // Control: output valid and character counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      chr_r       <= 4'd0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (load) chr_r <= final_beat ? 4'd0 : chr_r + 4'd1;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk) begin
    if (load) begin
      led_r <= head_job.led;
      if (head_job.is_reply) begin
        kind_r <= lpc_pkg::KIND_REPLY;
        char_r <= lpc_pkg::msg_char(head_job.msg, chr_r, head_job.digit);
        last_r <= final_beat;
      end else begin
        kind_r <= lpc_pkg::KIND_LED;
        char_r <= 8'd0;
        last_r <= 1'b0;
      end
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick and serial-byte beats into the LED pattern controller, mirrors
// its debouncing, pattern stepping and command replies in a local model, and
// checks every result beat in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int         RX_RING   = 20;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // index with no register behind it
  localparam logic [7:0] CR        = 8'h0D;
  localparam logic [7:0] LF        = 8'h0A;

  localparam logic [7:0] PATTERN_ROM [4][8] = '{
    '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80},
    '{8'h81, 8'h42, 8'h24, 8'h18, 8'h24, 8'h42, 8'h00, 8'h00},
    '{8'h88, 8'h44, 8'h22, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int PATTERN_LEN [4] = '{2, 8, 6, 4};

  typedef struct packed {
    logic       opcode;
    logic       run_pin;
    logic       program_pin;
    logic       speed_pin;
    logic [7:0] rx_byte;
  } ctrl_event_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] led;
    logic [7:0] ch;
    logic       last;
  } led_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_write_en = 1'b0;
  logic [1:0] cfg_index = lpc_pkg::CFG_SLOW_PERIOD;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_opcode = lpc_pkg::OP_TICK;
  logic       in_run_pin = 1'b1;
  logic       in_program_pin = 1'b1;
  logic       in_speed_pin = 1'b1;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_led;
  logic [7:0] out_reply_char;
  logic       out_last;

  led_pattern_controller DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_run_pin     (in_run_pin),
    .in_program_pin (in_program_pin),
    .in_speed_pin   (in_speed_pin),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_led        (out_led),
    .out_reply_char (out_reply_char),
    .out_last       (out_last)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be sent and LED/reply beats the controller owes us.
  ctrl_event_t queued_events[$];
  led_beat_t   due_beats[$];
  int          events_added = 0;
  int          mismatches = 0;
  int          beats_seen = 0;
  int          send_idle_pct = 15;
  int          recv_stall_pct = 15;
  logic [2:0]  btn_level = 3'b111;

  // Local copy of the controller state and its registers.
  logic [7:0] slow_ticks, fast_ticks, tick_cnt, led_now;
  logic [2:0] debounce_need, prog_sel;
  logic [2:0] raw_prev, level_now, level_prev;
  logic [2:0] rep_cnt [3];
  logic       step_pending, is_running, fast_mode;
  int         pat_pos [4];
  logic [7:0] rx_ring [RX_RING];
  int         rx_wr;

  task automatic reset_model();
    slow_ticks    = 8'd200;
    fast_ticks    = 8'd100;
    debounce_need = 3'd5;
    tick_cnt      = 8'd0;
    step_pending  = 1'b0;
    raw_prev      = 3'b111;
    level_now     = 3'b111;
    level_prev    = 3'b111;
    is_running    = 1'b0;
    prog_sel      = 3'd1;
    fast_mode     = 1'b0;
    led_now       = 8'd0;
    rx_wr         = 0;
    for (int i = 0; i < 3; i++) rep_cnt[i] = 3'd0;
    for (int i = 0; i < 4; i++) pat_pos[i] = 0;
    for (int i = 0; i < RX_RING; i++) rx_ring[i] = 8'h00;
  endtask

  // Queues one reply: the text, an optional digit, then CR LF.
  task automatic queue_reply(input string head, input logic [7:0] digit);
    logic [7:0] chars[$];
    led_beat_t  beat;
    for (int k = 0; k < head.len(); k++) chars.push_back(head[k]);
    if (digit != 8'h00) chars.push_back(digit);
    chars.push_back(CR);
    chars.push_back(LF);
    for (int k = 0; k < chars.size(); k++) begin
      beat.kind = lpc_pkg::KIND_REPLY;
      beat.led  = led_now;
      beat.ch   = chars[k];
      beat.last = (k == chars.size() - 1);
      due_beats.push_back(beat);
    end
  endtask

  // Decodes the first five ring entries after a closing bracket.
  task automatic answer_command();
    if (rx_ring[0] == lpc_pkg::CH_OPEN && rx_ring[1] == lpc_pkg::CH_O &&
        rx_ring[2] == lpc_pkg::CH_N && rx_ring[3] == lpc_pkg::CH_CLOSE) begin
      is_running = 1'b1;
      prog_sel   = 3'd1;
      queue_reply("UKLJUCENO", 8'h00);
    end else if (rx_ring[0] == lpc_pkg::CH_OPEN && rx_ring[1] == lpc_pkg::CH_O &&
                 rx_ring[2] == lpc_pkg::CH_F && rx_ring[3] == lpc_pkg::CH_F &&
                 rx_ring[4] == lpc_pkg::CH_CLOSE) begin
      is_running = 1'b0;
      queue_reply("ISKLJUCENO", 8'h00);
    end else if (rx_ring[0] == lpc_pkg::CH_OPEN && rx_ring[1] == lpc_pkg::CH_P &&
                 rx_ring[2] == lpc_pkg::CH_COLON &&
                 rx_ring[3] >= lpc_pkg::CH_1 && rx_ring[3] <= lpc_pkg::CH_4 &&
                 rx_ring[4] == lpc_pkg::CH_CLOSE) begin
      // The low bits of an ASCII digit are its value.
      prog_sel = rx_ring[3][2:0];
      queue_reply("PROGRAM", rx_ring[3]);
    end else if (rx_ring[0] == lpc_pkg::CH_OPEN && rx_ring[1] == lpc_pkg::CH_B &&
                 rx_ring[2] == lpc_pkg::CH_COLON &&
                 (rx_ring[3] == lpc_pkg::CH_1 || rx_ring[3] == lpc_pkg::CH_2) &&
                 rx_ring[4] == lpc_pkg::CH_CLOSE) begin
      fast_mode = (rx_ring[3] == lpc_pkg::CH_2);
      queue_reply("BRZINA", rx_ring[3]);
    end else begin
      queue_reply("GRESKA!", 8'h00);
    end
  endtask

  // Applies one accepted beat to the local state and queues what it yields.
  task automatic advance_controller(input ctrl_event_t ev);
    logic [7:0] period;
    logic [2:0] raw;
    int         p;
    int         idx;
    led_beat_t  beat;
    if (ev.opcode == lpc_pkg::OP_TICK) begin
      period   = fast_mode ? fast_ticks : slow_ticks;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt == period) begin
        tick_cnt     = 8'd0;
        step_pending = 1'b1;
      end

      // Debounce: a level is taken once enough equal samples repeat.
      raw = {ev.speed_pin, ev.program_pin, ev.run_pin};
      for (int i = 0; i < 3; i++) begin
        if (raw[i] == raw_prev[i]) begin
          rep_cnt[i] = rep_cnt[i] + 3'd1;
          if (rep_cnt[i] >= debounce_need) begin
            level_now[i] = raw[i];
            rep_cnt[i]   = 3'd0;
          end
        end else begin
          rep_cnt[i] = 3'd0;
        end
      end
      raw_prev = raw;

      // Falling edges of the clean levels act as button presses.
      if (level_prev[0] && !level_now[0]) begin
        is_running = !is_running;
        if (is_running) tick_cnt = 8'd0;
      end
      if (level_prev[2] && !level_now[2]) fast_mode = !fast_mode;
      if (level_prev[1] && !level_now[1]) begin
        prog_sel = prog_sel + 3'd1;
        if (prog_sel >= 3'd5 || prog_sel == 3'd0) prog_sel = 3'd1;
      end
      level_prev = level_now;

      // Show the next entry of the selected pattern when a step is due.
      if (is_running) begin
        if (step_pending && prog_sel >= 3'd1 && prog_sel <= 3'd4) begin
          p   = int'(prog_sel) - 1;
          idx = pat_pos[p];
          if (idx >= PATTERN_LEN[p]) idx = 0;
          led_now = PATTERN_ROM[p][idx];
          idx++;
          pat_pos[p]   = (idx >= PATTERN_LEN[p]) ? 0 : idx;
          step_pending = 1'b0;
        end
      end else begin
        led_now = 8'd0;
      end

      beat.kind = lpc_pkg::KIND_LED;
      beat.led  = led_now;
      beat.ch   = 8'h00;
      beat.last = 1'b0;
      due_beats.push_back(beat);
    end else begin
      if (ev.rx_byte == lpc_pkg::CH_OPEN) rx_wr = 0;
      if (rx_wr >= RX_RING) rx_wr = 0;
      rx_ring[rx_wr] = ev.rx_byte;
      if (ev.rx_byte == lpc_pkg::CH_CLOSE) begin
        answer_command();
        rx_ring[0] = 8'h00;
        rx_wr      = 0;
      end
      rx_wr = (rx_wr + 1) % RX_RING;
    end
  endtask

  // Source side: offers queued beats with random gaps, holding each until taken.
  ctrl_event_t on_wire;
  int          send_gap = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) advance_controller(on_wire);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (queued_events.size() > 0) begin
          on_wire = queued_events.pop_front();
          in_valid       <= 1'b1;
          in_opcode      <= on_wire.opcode;
          in_run_pin     <= on_wire.run_pin;
          in_program_pin <= on_wire.program_pin;
          in_speed_pin   <= on_wire.speed_pin;
          in_rx_byte     <= on_wire.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: checks each result beat and stalls in random bursts, once for
  // a long stretch so that the controller backs up into its input.
  led_beat_t want;
  int        recv_gap = 0;
  int        hold_left = 0;
  bit        held_once = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (due_beats.size() == 0) begin
          $error("unexpected result beat: kind %0d led %h reply_char %h last %0d",
                 out_kind, out_led, out_reply_char, out_last);
          mismatches++;
        end else begin
          want = due_beats.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_kind);
            mismatches++;
          end
          if (out_led !== want.led) begin
            $error("led: expected %h, actual %h", want.led, out_led);
            mismatches++;
          end
          if (out_reply_char !== want.ch) begin
            $error("reply_char: expected %h, actual %h", want.ch, out_reply_char);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            mismatches++;
          end
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && beats_seen >= 150) begin
        held_once = 1'b1;
        hold_left = 199;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        recv_gap = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus helpers.
  task automatic add_pins(input logic run, input logic prog, input logic speed);
    ctrl_event_t ev;
    ev.opcode      = lpc_pkg::OP_TICK;
    ev.run_pin     = run;
    ev.program_pin = prog;
    ev.speed_pin   = speed;
    ev.rx_byte     = 8'($urandom);
    queued_events.push_back(ev);
    events_added++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    ctrl_event_t ev;
    ev.opcode      = lpc_pkg::OP_BYTE;
    ev.run_pin     = 1'($urandom);
    ev.program_pin = 1'($urandom);
    ev.speed_pin   = 1'($urandom);
    ev.rx_byte     = b;
    queued_events.push_back(ev);
    events_added++;
  endtask

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k]);
  endtask

  // Buttons change now and then; single-tick glitches test the debouncer.
  task automatic add_tick();
    logic [2:0] glitch;
    for (int i = 0; i < 3; i++) if ($urandom_range(0, 11) == 0) btn_level[i] = !btn_level[i];
    for (int i = 0; i < 3; i++) glitch[i] = ($urandom_range(0, 19) == 0);
    add_pins(btn_level[0] ^ glitch[0], btn_level[1] ^ glitch[1], btn_level[2] ^ glitch[2]);
  endtask

  // A command with random content, optionally with one byte hit or dropped.
  task automatic add_command(input bit broken);
    logic [7:0] text[$];
    int         k;
    case ($urandom_range(0, 3))
      0:       text = {lpc_pkg::CH_OPEN, lpc_pkg::CH_O, lpc_pkg::CH_N, lpc_pkg::CH_CLOSE};
      1:       text = {lpc_pkg::CH_OPEN, lpc_pkg::CH_O, lpc_pkg::CH_F, lpc_pkg::CH_F,
                       lpc_pkg::CH_CLOSE};
      2:       text = {lpc_pkg::CH_OPEN, lpc_pkg::CH_P, lpc_pkg::CH_COLON,
                       8'($urandom_range(lpc_pkg::CH_1 - 1, lpc_pkg::CH_4 + 1)),
                       lpc_pkg::CH_CLOSE};
      default: text = {lpc_pkg::CH_OPEN, lpc_pkg::CH_B, lpc_pkg::CH_COLON,
                       8'($urandom_range(lpc_pkg::CH_1 - 1, lpc_pkg::CH_2 + 1)),
                       lpc_pkg::CH_CLOSE};
    endcase
    if (broken) begin
      k = $urandom_range(0, text.size() - 1);
      if ($urandom_range(0, 1) == 0) text[k] = 8'($urandom);
      else text.delete(k);
    end
    foreach (text[j]) add_byte(text[j]);
  endtask

  // Mostly tick runs and well-formed commands, the rest broken ones and noise.
  task automatic add_random_phase(input int n);
    int stop_at;
    int len;
    stop_at = events_added + n;
    while (events_added < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: repeat ($urandom_range(1, 12)) add_tick();
        6, 7:             add_command(1'b0);
        8:                add_command(1'b1);
        default: begin
          // Long noise runs wrap the receive ring.
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 4);
          repeat (len) add_byte(8'($urandom));
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      lpc_pkg::CFG_SLOW_PERIOD:  slow_ticks = data;
      lpc_pkg::CFG_FAST_PERIOD:  fast_ticks = data;
      lpc_pkg::CFG_STABLE_COUNT: debounce_need = data[2:0];
      default:                   ;
    endcase
  endtask

  task automatic configure(input logic [7:0] slow, input logic [7:0] fast,
                           input logic [7:0] debounce, input bit poke_spare);
    write_reg(lpc_pkg::CFG_SLOW_PERIOD, slow);
    write_reg(lpc_pkg::CFG_FAST_PERIOD, fast);
    write_reg(lpc_pkg::CFG_STABLE_COUNT, debounce);
    if (poke_spare) write_reg(CFG_SPARE, 8'($urandom));
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Waits until every beat is sent and answered, then lets the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_events.size() != 0 || in_valid || due_beats.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Main sequence.
  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: presses on all buttons, the on, off, speed and error replies, extreme bytes.
    configure(8'd2, 8'd1, 8'd1, 1'b0);
    add_pins(1'b1, 1'b1, 1'b1);
    add_pins(1'b0, 1'b0, 1'b0);
    add_pins(1'b0, 1'b0, 1'b0);
    add_pins(1'b1, 1'b1, 1'b1);
    add_pins(1'b1, 1'b1, 1'b1);
    add_text("(OFF)");
    add_pins(1'b1, 1'b1, 1'b1);
    add_text("(ON)");
    add_text("(B:2)");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(lpc_pkg::CH_CLOSE);
    add_pins(1'b1, 1'b1, 1'b1);
    wait_drained();

    // Short periods, light debounce.
    configure(8'd4, 8'd2, 8'd2, 1'b0);
    add_random_phase(62);
    wait_drained();

    // Longest slow period, one-tick fast period, strongest debounce.
    recv_stall_pct = 30;
    send_idle_pct  = 30;
    configure(8'd255, 8'd1, 8'd7, 1'b0);
    add_random_phase(62);
    wait_drained();

    // Zero slow period, zero stable count through a masked write, spare index.
    configure(8'd0, 8'd3, 8'h08, 1'b1);
    add_random_phase(62);
    wait_drained();

    // Fast period at its maximum.
    recv_stall_pct = 10;
    send_idle_pct  = 10;
    configure(8'd1, 8'd255, 8'd1, 1'b0);
    add_random_phase(62);
    wait_drained();

    // Final stretch with no gaps or stalls and random settings.
    recv_stall_pct = 0;
    send_idle_pct  = 0;
    configure(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)), 8'($urandom), 1'b1);
    add_random_phase(62);
    wait_drained();

    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
